### sv/zors_pkg.sv
// ----------------------------------------------------------------------------
// zors_pkg: shared types and constants for the zero-offset statistics block
// Widths, register indexes, arithmetic opcodes and the records that pass
// between the accumulator front end, the record queue and the math engine.
// ----------------------------------------------------------------------------
package zors_pkg;

  localparam int SAMPLE_W         = 16;
  localparam int COUNT_W          = 16;
  localparam int ROUND_W          = 10;
  localparam int TICKS_PER_SECOND = 6250;

  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;
  localparam int CFG_W   = 16;

  localparam int ST_W    = 32;
  localparam int SV_W    = 32;
  localparam int SQ_W    = 48;
  localparam int SOM_W   = 34;
  localparam int SOMS_W  = 58;

  localparam int NUM_W     = 96;
  localparam int DEN_W     = 64;
  localparam int ROOT_IN_W = 48;
  localparam int Q8_W      = 24;
  localparam int SLOPE_W   = 48;
  localparam int CNT_W     = $clog2(NUM_W);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [DEN_W-1:0]   SLOPE_SCALE = DEN_W'(TICKS_PER_SECOND) << 16;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
  localparam logic [ROUND_W-1:0] ROUND_MAX   = '1;
  localparam logic [Q8_W-1:0]    Q8_MAX      = '1;

  localparam logic [CFG_W-1:0] SPR_RESET       = 16'd62500;
  localparam logic [CFG_W-1:0] ROUNDS_RESET    = 16'd10;
  localparam logic [CFG_W-1:0] RAIL_HIGH_RESET = 16'd65280;
  localparam logic [CFG_W-1:0] RAIL_LOW_RESET  = 16'd255;

  typedef enum logic [1:0] {
    REG_SPR       = 2'd0,
    REG_ROUNDS    = 2'd1,
    REG_RAIL_HIGH = 2'd2,
    REG_RAIL_LOW  = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_DIV  = 2'd1,
    OP_SQRT = 2'd2
  } arith_op_t;

  typedef struct packed {
    logic [CFG_W-1:0]   samples_per_round;
    logic [ROUND_W-1:0] rounds_total;
    logic [CFG_W-1:0]   rail_high;
    logic [CFG_W-1:0]   rail_low;
  } cfg_t;

  typedef struct packed {
    logic [COUNT_W-1:0]  n;
    logic [ST_W-1:0]     st;
    logic [SV_W-1:0]     sv;
    logic [SQ_W-1:0]     stsq;
    logic [SQ_W-1:0]     stv;
    logic [SQ_W-1:0]     svsq;
    logic [SAMPLE_W-1:0] min_code;
    logic [SAMPLE_W-1:0] max_code;
    logic                railed;
    logic [ROUND_W-1:0]  round_index;
    logic                all_done;
  } round_rec_t;

  typedef struct packed {
    logic            start;
    arith_op_t       op;
    logic [NUM_W-1:0] a;
    logic [DEN_W-1:0] b;
  } arith_req_t;

  typedef struct packed {
    logic [Q8_W-1:0]     mean_q8;
    logic [Q8_W-1:0]     std_q8;
    logic [SLOPE_W-1:0]  slope_q16;
    logic [SAMPLE_W-1:0] min_code;
    logic [SAMPLE_W-1:0] max_code;
    logic                railed;
    logic [ROUND_W-1:0]  round_index;
    logic [Q8_W-1:0]     zero_offset_q8;
    logic [Q8_W-1:0]     floor_noise_q8;
    logic                all_done;
  } result_t;

endpackage

### sv/zors_front.sv
// ----------------------------------------------------------------------------
// zors_front: per-sample accumulator
// Sums t, v, t*t, t*v, v*v and tracks min/max; closes a round into a record.
// ----------------------------------------------------------------------------
module zors_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept_i,
  input  logic [15:0]           sample_i,
  input  zors_pkg::cfg_t        cfg_i,
  output zors_pkg::round_rec_t  rec_o,
  output logic                  rec_push_o
);
  import zors_pkg::*;

  logic [COUNT_W-1:0]  tick_r, tick_nxt, n;
  logic [ST_W-1:0]     st_r, st_nxt;
  logic [SV_W-1:0]     sv_r, sv_nxt;
  logic [SQ_W-1:0]     stsq_r, stsq_nxt, stv_r, stv_nxt, svsq_r, svsq_nxt;
  logic [SAMPLE_W-1:0] min_r, min_nxt, max_r, max_nxt, v, min_new, max_new;
  logic [ROUND_W-1:0]  rounds_r, rounds_nxt, rounds_inc;
  logic                stopped_r, stopped_nxt;
  logic [2*COUNT_W-1:0]        tt;
  logic [COUNT_W+SAMPLE_W-1:0] tv;
  logic [2*SAMPLE_W-1:0]       vv;
  logic                active, round_end, done;

  always_comb begin
    v          = sample_i[SAMPLE_W-1:0];
    active     = accept_i & ~stopped_r;
    n          = tick_r + 1'b1;
    tt         = (2*COUNT_W)'(tick_r) * (2*COUNT_W)'(tick_r);
    tv         = (COUNT_W+SAMPLE_W)'(tick_r) * (COUNT_W+SAMPLE_W)'(v);
    vv         = (2*SAMPLE_W)'(v) * (2*SAMPLE_W)'(v);
    min_new    = (v < min_r) ? v : min_r;
    max_new    = (v > max_r) ? v : max_r;
    round_end  = (32'(n) >= 32'(cfg_i.samples_per_round)) || (n == COUNT_MAX);
    rounds_inc = rounds_r + 1'b1;
    done       = (32'(rounds_inc) >= 32'(cfg_i.rounds_total)) || (rounds_inc == ROUND_MAX);

    rec_o.n           = n;
    rec_o.st          = st_r + ST_W'(tick_r);
    rec_o.sv          = sv_r + SV_W'(v);
    rec_o.stsq        = stsq_r + SQ_W'(tt);
    rec_o.stv         = stv_r + SQ_W'(tv);
    rec_o.svsq        = svsq_r + SQ_W'(vv);
    rec_o.min_code    = min_new;
    rec_o.max_code    = max_new;
    rec_o.railed      = (16'(max_new) >= cfg_i.rail_high) || (16'(min_new) <= cfg_i.rail_low);
    rec_o.round_index = rounds_inc;
    rec_o.all_done    = done;
    rec_push_o        = active & round_end;

    tick_nxt    = tick_r;
    st_nxt      = st_r;
    sv_nxt      = sv_r;
    stsq_nxt    = stsq_r;
    stv_nxt     = stv_r;
    svsq_nxt    = svsq_r;
    min_nxt     = min_r;
    max_nxt     = max_r;
    rounds_nxt  = rounds_r;
    stopped_nxt = stopped_r;
    if (active) begin
      if (round_end) begin
        // close the round: clear sums, advance round count
        tick_nxt    = '0;
        st_nxt      = '0;
        sv_nxt      = '0;
        stsq_nxt    = '0;
        stv_nxt     = '0;
        svsq_nxt    = '0;
        min_nxt     = '1;
        max_nxt     = '0;
        rounds_nxt  = rounds_inc;
        stopped_nxt = done;
      end else begin
        tick_nxt = n;
        st_nxt   = rec_o.st;
        sv_nxt   = rec_o.sv;
        stsq_nxt = rec_o.stsq;
        stv_nxt  = rec_o.stv;
        svsq_nxt = rec_o.svsq;
        min_nxt  = min_new;
        max_nxt  = max_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r    <= '0;
      st_r      <= '0;
      sv_r      <= '0;
      stsq_r    <= '0;
      stv_r     <= '0;
      svsq_r    <= '0;
      min_r     <= '1;
      max_r     <= '0;
      rounds_r  <= '0;
      stopped_r <= 1'b0;
    end else begin
      tick_r    <= tick_nxt;
      st_r      <= st_nxt;
      sv_r      <= sv_nxt;
      stsq_r    <= stsq_nxt;
      stv_r     <= stv_nxt;
      svsq_r    <= svsq_nxt;
      min_r     <= min_nxt;
      max_r     <= max_nxt;
      rounds_r  <= rounds_nxt;
      stopped_r <= stopped_nxt;
    end
  end

endmodule

### sv/zors_queue.sv
// ----------------------------------------------------------------------------
// zors_queue: short record queue
// Decouples the accumulator from the math engine.
// ----------------------------------------------------------------------------
module zors_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_i,
  input  zors_pkg::round_rec_t data_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output zors_pkg::round_rec_t data_o,
  output logic                 empty_o
);
  import zors_pkg::*;

  round_rec_t          mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  logic                do_push, do_pop;

  always_comb begin
    full_o     = (count_r == QCNT_W'(QUEUE_DEPTH));
    empty_o    = (count_r == '0);
    do_push    = push_i & ~full_o;
    do_pop     = pop_i & ~empty_o;
    data_o     = mem[rd_ptr_r];
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= data_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

### sv/zors_arith.sv
// ----------------------------------------------------------------------------
// zors_arith: shared multi-cycle arithmetic unit
// Shift-add multiply, restoring divide and digit-by-digit square root.
// ----------------------------------------------------------------------------
module zors_arith (
  input  logic                          clk,
  input  logic                          rst_n,
  input  zors_pkg::arith_req_t          req_i,
  output logic                          done_o,
  output logic [zors_pkg::NUM_W-1:0]    res_o
);
  import zors_pkg::*;

  typedef enum logic [3:0] {
    A_IDLE = 4'b0001,
    A_MUL  = 4'b0010,
    A_DIV  = 4'b0100,
    A_SQRT = 4'b1000
  } arith_state_t;

  arith_state_t      state_r, state_nxt;
  logic [NUM_W-1:0]  acc_r, acc_nxt, sh_r, sh_nxt, res_r, res_nxt;
  logic [DEN_W-1:0]  mp_r, mp_nxt;
  logic [DEN_W:0]    rem_r, rem_nxt, rem_sh;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              done_r, done_nxt, ge;
  logic [ROOT_IN_W:0] trial;

  assign done_o = done_r;
  assign res_o  = res_r;

  always_comb begin
    state_nxt = state_r;
    acc_nxt   = acc_r;
    sh_nxt    = sh_r;
    mp_nxt    = mp_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    res_nxt   = res_r;
    done_nxt  = 1'b0;
    rem_sh    = {rem_r[DEN_W-1:0], sh_r[NUM_W-1]};
    ge        = rem_sh >= {1'b0, mp_r};
    trial     = {1'b0, sh_r[ROOT_IN_W-1:0]} + {1'b0, mp_r[ROOT_IN_W-1:0]};
    unique case (state_r)
      A_IDLE: begin
        if (req_i.start) begin
          unique case (req_i.op)
            OP_MUL: begin
              acc_nxt   = '0;
              sh_nxt    = NUM_W'(req_i.a[DEN_W-1:0]);
              mp_nxt    = req_i.b;
              state_nxt = A_MUL;
            end
            OP_DIV: begin
              sh_nxt    = req_i.a;
              mp_nxt    = req_i.b;
              rem_nxt   = '0;
              cnt_nxt   = '0;
              state_nxt = A_DIV;
            end
            OP_SQRT: begin
              acc_nxt   = NUM_W'(req_i.a[ROOT_IN_W-1:0]);
              sh_nxt    = '0;
              mp_nxt    = DEN_W'(1) << (ROOT_IN_W - 2);
              state_nxt = A_SQRT;
            end
            default: state_nxt = A_IDLE;
          endcase
        end
      end
      A_MUL: begin
        if (mp_r == '0) begin
          res_nxt   = acc_r;
          done_nxt  = 1'b1;
          state_nxt = A_IDLE;
        end else begin
          if (mp_r[0]) begin
            acc_nxt = acc_r + sh_r;
          end
          sh_nxt = sh_r << 1;
          mp_nxt = mp_r >> 1;
        end
      end
      A_DIV: begin
        // one quotient bit per cycle, most significant first
        rem_nxt = ge ? (rem_sh - {1'b0, mp_r}) : rem_sh;
        sh_nxt  = {sh_r[NUM_W-2:0], ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          res_nxt   = sh_nxt;
          done_nxt  = 1'b1;
          state_nxt = A_IDLE;
        end
      end
      A_SQRT: begin
        if ({1'b0, acc_r[ROOT_IN_W-1:0]} >= trial) begin
          acc_nxt = NUM_W'(acc_r[ROOT_IN_W-1:0] - trial[ROOT_IN_W-1:0]);
          sh_nxt  = NUM_W'((sh_r[ROOT_IN_W-1:0] >> 1) + mp_r[ROOT_IN_W-1:0]);
        end else begin
          sh_nxt  = NUM_W'(sh_r[ROOT_IN_W-1:0] >> 1);
        end
        mp_nxt = mp_r >> 2;
        if (mp_r == DEN_W'(1)) begin
          res_nxt   = sh_nxt;
          done_nxt  = 1'b1;
          state_nxt = A_IDLE;
        end
      end
      default: state_nxt = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    sh_r  <= sh_nxt;
    mp_r  <= mp_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

endmodule

### sv/zors_back.sv
// ----------------------------------------------------------------------------
// zors_back: round statistics sequencer
// Walks one round record through the arithmetic unit and holds the result.
// ----------------------------------------------------------------------------
module zors_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  zors_pkg::round_rec_t          rec_i,
  input  logic                          rec_empty_i,
  output logic                          rec_pop_o,
  output zors_pkg::arith_req_t          req_o,
  input  logic                          arith_done_i,
  input  logic [zors_pkg::NUM_W-1:0]    arith_res_i,
  output zors_pkg::result_t             res_o,
  output logic                          res_empty_o,
  input  logic                          res_pop_i
);
  import zors_pkg::*;

  typedef enum logic [20:0] {
    S_IDLE  = 21'd1 << 0,
    S_MEAN  = 21'd1 << 1,
    S_A1    = 21'd1 << 2,
    S_B1    = 21'd1 << 3,
    S_NN    = 21'd1 << 4,
    S_SDIV  = 21'd1 << 5,
    S_SSQ   = 21'd1 << 6,
    S_A2    = 21'd1 << 7,
    S_B2    = 21'd1 << 8,
    S_P     = 21'd1 << 9,
    S_Q     = 21'd1 << 10,
    S_NUM   = 21'd1 << 11,
    S_QDIV  = 21'd1 << 12,
    S_CROSS = 21'd1 << 13,
    S_ZERO  = 21'd1 << 14,
    S_A3    = 21'd1 << 15,
    S_B3    = 21'd1 << 16,
    S_RR    = 21'd1 << 17,
    S_NDIV  = 21'd1 << 18,
    S_NSQ   = 21'd1 << 19,
    S_EMIT  = 21'd1 << 20
  } seq_state_t;

  seq_state_t         state_r, state_nxt;
  logic               issued_r, issued_nxt, out_valid_r, out_valid_nxt;
  logic               neg_r, neg_nxt, op_done;
  round_rec_t         rec_r, rec_nxt;
  result_t            out_r, out_nxt;
  logic [NUM_W-1:0]   ra_r, ra_nxt, rb_r, rb_nxt;
  logic [DEN_W-1:0]   rc_r, rc_nxt;
  logic [Q8_W-1:0]    mean_r, mean_nxt, std_r, std_nxt, zero_r, zero_nxt;
  logic [Q8_W-1:0]    noise_r, noise_nxt;
  logic [SLOPE_W-1:0] slope_r, slope_nxt;
  logic [SOM_W-1:0]   som_r, som_nxt;
  logic [SOMS_W-1:0]  soms_r, soms_nxt;

  assign res_o       = out_r;
  assign res_empty_o = ~out_valid_r;

  // operand select for the arithmetic unit
  always_comb begin
    req_o       = '0;
    req_o.start = (state_r != S_IDLE) && (state_r != S_EMIT) && !issued_r;
    unique case (state_r)
      S_MEAN:  begin req_o.op = OP_DIV;  req_o.a = NUM_W'({rec_r.sv, 8'b0});
                     req_o.b = DEN_W'(rec_r.n); end
      S_A1:    begin req_o.op = OP_MUL;  req_o.a = NUM_W'(rec_r.svsq);
                     req_o.b = DEN_W'(rec_r.n); end
      S_B1:    begin req_o.op = OP_MUL;  req_o.a = NUM_W'(rec_r.sv);
                     req_o.b = DEN_W'(rec_r.sv); end
      S_NN:    begin req_o.op = OP_MUL;  req_o.a = NUM_W'(rec_r.n);
                     req_o.b = DEN_W'(rec_r.n); end
      S_SDIV:  begin req_o.op = OP_DIV;  req_o.a = (ra_r - rb_r) << 16;
                     req_o.b = rc_r; end
      S_SSQ:   begin req_o.op = OP_SQRT; req_o.a = ra_r; end
      S_A2:    begin req_o.op = OP_MUL;  req_o.a = NUM_W'(rec_r.stsq);
                     req_o.b = DEN_W'(rec_r.n); end
      S_B2:    begin req_o.op = OP_MUL;  req_o.a = NUM_W'(rec_r.st);
                     req_o.b = DEN_W'(rec_r.st); end
      S_P:     begin req_o.op = OP_MUL;  req_o.a = NUM_W'(rec_r.stv);
                     req_o.b = DEN_W'(rec_r.n); end
      S_Q:     begin req_o.op = OP_MUL;  req_o.a = NUM_W'(rec_r.st);
                     req_o.b = DEN_W'(rec_r.sv); end
      S_NUM:   begin req_o.op = OP_MUL;  req_o.a = ra_r; req_o.b = SLOPE_SCALE; end
      S_QDIV:  begin req_o.op = OP_DIV;  req_o.a = ra_r; req_o.b = rc_r; end
      S_CROSS: begin req_o.op = OP_MUL;  req_o.a = NUM_W'(mean_r);
                     req_o.b = DEN_W'(mean_r); end
      S_ZERO:  begin req_o.op = OP_DIV;  req_o.a = NUM_W'(som_r);
                     req_o.b = DEN_W'(rec_r.round_index); end
      S_A3:    begin req_o.op = OP_MUL;  req_o.a = NUM_W'(soms_r);
                     req_o.b = DEN_W'(rec_r.round_index); end
      S_B3:    begin req_o.op = OP_MUL;  req_o.a = NUM_W'(som_r);
                     req_o.b = DEN_W'(som_r); end
      S_RR:    begin req_o.op = OP_MUL;  req_o.a = NUM_W'(rec_r.round_index);
                     req_o.b = DEN_W'(rec_r.round_index); end
      S_NDIV:  begin req_o.op = OP_DIV;  req_o.a = ra_r - rb_r; req_o.b = rc_r; end
      S_NSQ:   begin req_o.op = OP_SQRT; req_o.a = ra_r; end
      default: req_o.start = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    issued_nxt    = issued_r;
    out_valid_nxt = out_valid_r;
    neg_nxt       = neg_r;
    rec_nxt       = rec_r;
    out_nxt       = out_r;
    ra_nxt        = ra_r;
    rb_nxt        = rb_r;
    rc_nxt        = rc_r;
    mean_nxt      = mean_r;
    std_nxt       = std_r;
    zero_nxt      = zero_r;
    noise_nxt     = noise_r;
    slope_nxt     = slope_r;
    som_nxt       = som_r;
    soms_nxt      = soms_r;
    rec_pop_o     = 1'b0;
    op_done       = issued_r & arith_done_i;

    if (req_o.start) begin
      issued_nxt = 1'b1;
    end
    if (op_done) begin
      issued_nxt = 1'b0;
    end
    if (res_pop_i && out_valid_r) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (!rec_empty_i) begin
          rec_nxt   = rec_i;
          rec_pop_o = 1'b1;
          state_nxt = S_MEAN;
        end
      end
      S_MEAN: if (op_done) begin
        mean_nxt  = arith_res_i[Q8_W-1:0];
        state_nxt = S_A1;
      end
      S_A1: if (op_done) begin
        ra_nxt    = arith_res_i;
        state_nxt = S_B1;
      end
      S_B1: if (op_done) begin
        rb_nxt    = arith_res_i;
        state_nxt = S_NN;
      end
      S_NN: if (op_done) begin
        rc_nxt = arith_res_i[DEN_W-1:0];
        if (ra_r < rb_r) begin
          std_nxt   = '0;
          state_nxt = S_A2;
        end else begin
          state_nxt = S_SDIV;
        end
      end
      S_SDIV: if (op_done) begin
        if (|arith_res_i[NUM_W-1:ROOT_IN_W]) begin
          std_nxt   = Q8_MAX;
          state_nxt = S_A2;
        end else begin
          ra_nxt    = arith_res_i;
          state_nxt = S_SSQ;
        end
      end
      S_SSQ: if (op_done) begin
        std_nxt   = arith_res_i[Q8_W-1:0];
        state_nxt = S_A2;
      end
      S_A2: if (op_done) begin
        ra_nxt    = arith_res_i;
        state_nxt = S_B2;
      end
      S_B2: if (op_done) begin
        // slope only when the denominator is positive
        if (arith_res_i < ra_r) begin
          rc_nxt    = DEN_W'(ra_r - arith_res_i);
          state_nxt = S_P;
        end else begin
          slope_nxt = '0;
          state_nxt = S_CROSS;
        end
      end
      S_P: if (op_done) begin
        ra_nxt    = arith_res_i;
        state_nxt = S_Q;
      end
      S_Q: if (op_done) begin
        neg_nxt   = ra_r < arith_res_i;
        ra_nxt    = (ra_r < arith_res_i) ? (arith_res_i - ra_r) : (ra_r - arith_res_i);
        state_nxt = S_NUM;
      end
      S_NUM: if (op_done) begin
        ra_nxt    = arith_res_i;
        state_nxt = S_QDIV;
      end
      S_QDIV: if (op_done) begin
        if (|arith_res_i[NUM_W-1:SLOPE_W-1]) begin
          slope_nxt = neg_r ? {1'b1, {(SLOPE_W-1){1'b0}}} : {1'b0, {(SLOPE_W-1){1'b1}}};
        end else begin
          slope_nxt = neg_r ? (SLOPE_W'(0) - arith_res_i[SLOPE_W-1:0])
                            : arith_res_i[SLOPE_W-1:0];
        end
        state_nxt = S_CROSS;
      end
      S_CROSS: if (op_done) begin
        som_nxt   = som_r + SOM_W'(mean_r);
        soms_nxt  = soms_r + arith_res_i[SOMS_W-1:0];
        state_nxt = S_ZERO;
      end
      S_ZERO: if (op_done) begin
        zero_nxt  = arith_res_i[Q8_W-1:0];
        state_nxt = S_A3;
      end
      S_A3: if (op_done) begin
        ra_nxt    = arith_res_i;
        state_nxt = S_B3;
      end
      S_B3: if (op_done) begin
        rb_nxt    = arith_res_i;
        state_nxt = S_RR;
      end
      S_RR: if (op_done) begin
        rc_nxt = arith_res_i[DEN_W-1:0];
        if (ra_r < rb_r) begin
          noise_nxt = '0;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_NDIV;
        end
      end
      S_NDIV: if (op_done) begin
        if (|arith_res_i[NUM_W-1:ROOT_IN_W]) begin
          noise_nxt = Q8_MAX;
          state_nxt = S_EMIT;
        end else begin
          ra_nxt    = arith_res_i;
          state_nxt = S_NSQ;
        end
      end
      S_NSQ: if (op_done) begin
        noise_nxt = arith_res_i[Q8_W-1:0];
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        // hold until the output register is free
        if (!out_valid_r) begin
          out_nxt.mean_q8        = mean_r;
          out_nxt.std_q8         = std_r;
          out_nxt.slope_q16      = slope_r;
          out_nxt.min_code       = rec_r.min_code;
          out_nxt.max_code       = rec_r.max_code;
          out_nxt.railed         = rec_r.railed;
          out_nxt.round_index    = rec_r.round_index;
          out_nxt.zero_offset_q8 = zero_r;
          out_nxt.floor_noise_q8 = noise_r;
          out_nxt.all_done       = rec_r.all_done;
          out_valid_nxt          = 1'b1;
          state_nxt              = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    rec_r   <= rec_nxt;
    out_r   <= out_nxt;
    ra_r    <= ra_nxt;
    rb_r    <= rb_nxt;
    rc_r    <= rc_nxt;
    neg_r   <= neg_nxt;
    mean_r  <= mean_nxt;
    std_r   <= std_nxt;
    zero_r  <= zero_nxt;
    noise_r <= noise_nxt;
    slope_r <= slope_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
      som_r       <= '0;
      soms_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      issued_r    <= issued_nxt;
      out_valid_r <= out_valid_nxt;
      som_r       <= som_nxt;
      soms_r      <= soms_nxt;
    end
  end

endmodule

### sv/zero_offset_regression_stats.sv
// ----------------------------------------------------------------------------
// zero_offset_regression_stats: per-round converter statistics
// Round mean, deviation, least-squares slope and cross-round offset/noise.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue (push/full/in_sample): one converter code per item. While
//   the record queue has room, full stays low and one item is taken every
//   cycle. A round closes after samples_per_round items, or after one item if it is zero.
//   Result queue (empty/pop/out_*): one item per finished round, shown while
//   empty is low and held until popped.
//   Config (APB, pready tied high): samples_per_round at 0x0, rounds_total at
//   0x4, rail_high at 0x8, rail_low at 0xC. Write only while idle.
// Math: once the last item of a round is in, the shared bit-serial
//   multiply/divide/root unit does up to five divides, two square roots and
//   a dozen shift-add multiplies before the round result appears.
// Throughput: one item per cycle during a round. Two closed rounds can wait
//   in the record queue; rounds shorter than the math time stall the input.
// Reset: clears all sums, the round count and the result valid flag and loads
//   the default configuration. After the final round, items are still taken
//   but dropped. If the receiver stalls, the result holds and the engine
//   waits; the input then stalls once the record queue fills.
// ----------------------------------------------------------------------------
module zero_offset_regression_stats (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [15:0]        in_sample,
  output logic               empty,
  input  logic               pop,
  output logic [23:0]        out_mean_q8,
  output logic [23:0]        out_std_q8,
  output logic signed [47:0] out_slope_q16,
  output logic [15:0]        out_min_code,
  output logic [15:0]        out_max_code,
  output logic               out_railed,
  output logic [9:0]         out_round_index,
  output logic [23:0]        out_zero_offset_q8,
  output logic [23:0]        out_floor_noise_q8,
  output logic               out_all_done,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import zors_pkg::*;

  cfg_t        cfg_r, cfg_nxt;
  round_rec_t  front_rec, q_rec;
  logic        rec_push, q_full, q_empty, q_pop, accept, cfg_wr;
  arith_req_t  req;
  logic        arith_done;
  logic [NUM_W-1:0] arith_res;
  result_t     res;
  reg_idx_t    reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  // register file: write on the access phase, read back always
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (reg_idx)
        REG_SPR:       cfg_nxt.samples_per_round = pwdata[CFG_W-1:0];
        REG_ROUNDS:    cfg_nxt.rounds_total      = pwdata[ROUND_W-1:0];
        REG_RAIL_HIGH: cfg_nxt.rail_high         = pwdata[CFG_W-1:0];
        REG_RAIL_LOW:  cfg_nxt.rail_low          = pwdata[CFG_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
    unique case (reg_idx)
      REG_SPR:       prdata = DATA_W'(cfg_r.samples_per_round);
      REG_ROUNDS:    prdata = DATA_W'(cfg_r.rounds_total);
      REG_RAIL_HIGH: prdata = DATA_W'(cfg_r.rail_high);
      REG_RAIL_LOW:  prdata = DATA_W'(cfg_r.rail_low);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.samples_per_round <= SPR_RESET;
      cfg_r.rounds_total      <= ROUNDS_RESET[ROUND_W-1:0];
      cfg_r.rail_high         <= RAIL_HIGH_RESET;
      cfg_r.rail_low          <= RAIL_LOW_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // stall input only when no room is left for a closed round
  assign full   = q_full;
  assign accept = push & ~q_full;

  zors_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept_i   (accept),
    .sample_i   (in_sample),
    .cfg_i      (cfg_r),
    .rec_o      (front_rec),
    .rec_push_o (rec_push)
  );

  zors_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (rec_push),
    .data_i  (front_rec),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rec),
    .empty_o (q_empty)
  );

  zors_arith u_arith (
    .clk    (clk),
    .rst_n  (rst_n),
    .req_i  (req),
    .done_o (arith_done),
    .res_o  (arith_res)
  );

  zors_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .rec_i        (q_rec),
    .rec_empty_i  (q_empty),
    .rec_pop_o    (q_pop),
    .req_o        (req),
    .arith_done_i (arith_done),
    .arith_res_i  (arith_res),
    .res_o        (res),
    .res_empty_o  (empty),
    .res_pop_i    (pop)
  );

  assign out_mean_q8        = res.mean_q8;
  assign out_std_q8         = res.std_q8;
  assign out_slope_q16      = res.slope_q16;
  assign out_min_code       = 16'(res.min_code);
  assign out_max_code       = 16'(res.max_code);
  assign out_railed         = res.railed;
  assign out_round_index    = res.round_index;
  assign out_zero_offset_q8 = res.zero_offset_q8;
  assign out_floor_noise_q8 = res.floor_noise_q8;
  assign out_all_done       = res.all_done;

endmodule

### sv/zors_checker.sv
// ----------------------------------------------------------------------------
// zors_checker: port-level checks for zero_offset_regression_stats
// Watches the result queue ports; bound to the top level.
// ----------------------------------------------------------------------------
module zors_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        empty,
  input logic        pop,
  input logic [23:0] out_mean_q8,
  input logic [15:0] out_min_code,
  input logic [15:0] out_max_code,
  input logic [9:0]  out_round_index,
  input logic        out_all_done
);

  // a waiting item holds until it is popped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_mean_q8) && $stable(out_round_index))
    else $error("result changed while waiting");

  // every round has at least one sample
  a_minmax: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> out_min_code <= out_max_code)
    else $error("round min above max");

  a_index: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> out_round_index != 10'd0)
    else $error("round index zero");

  // nothing follows the final round
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && pop && out_all_done |=> empty)
    else $error("result after final round");

endmodule

bind zero_offset_regression_stats zors_checker u_zors_checker (.*);

### tb/tb_zero_offset_regression_stats.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_zero_offset_regression_stats: self-checking bench for the round statistics block
// Drives converter codes through the input queue under random gaps, pops round
// results under random stalls and checks every field against a bit-exact
// fixed-point predictor of the sums, mean, deviation, slope and offset/noise.
// ----------------------------------------------------------------------------
module tb_zero_offset_regression_stats;
  import zors_pkg::*;

  typedef logic [127:0] w128_t;

  logic clk, rst_n;
  logic push, full, empty, pop;
  logic [15:0] in_sample;
  logic psel, penable, pwrite, pready;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;
  result_t got;

  zero_offset_regression_stats dut (
    .clk(clk), .rst_n(rst_n),
    .push(push), .full(full), .in_sample(in_sample),
    .empty(empty), .pop(pop),
    .out_mean_q8(got.mean_q8), .out_std_q8(got.std_q8),
    .out_slope_q16(got.slope_q16), .out_min_code(got.min_code),
    .out_max_code(got.max_code), .out_railed(got.railed),
    .out_round_index(got.round_index), .out_zero_offset_q8(got.zero_offset_q8),
    .out_floor_noise_q8(got.floor_noise_q8), .out_all_done(got.all_done),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Predictor copy of configuration and round state
  logic [15:0] spr_m, rail_hi_m, rail_lo_m;
  logic [9:0]  rounds_total_m, rounds_m;
  logic [15:0] tick_m, min_m, max_m;
  logic [31:0] st_m, sv_m;
  logic [47:0] stsq_m, stv_m, svsq_m;
  logic [33:0] som_m;
  logic [57:0] soms_m;
  logic        stopped_m;

  result_t round_results_due[$];
  int errors = 0, samples_sent = 0, rounds_seen = 0;
  bit fast_feed = 0;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Hang guard: far above the slowest legal run
  initial begin
    #400_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic logic [63:0] isqrt(logic [63:0] x);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // floor(sqrt(num/den)), clipped to 24 bits
  function automatic logic [23:0] root_ratio_q8(w128_t num, logic [63:0] den);
    w128_t q;
    logic [63:0] s;
    q = num / w128_t'(den);
    if (q[127:64] != 0) return Q8_MAX;
    s = isqrt(q[63:0]);
    return (s > 64'hFFFFFF) ? Q8_MAX : s[23:0];
  endfunction

  task automatic clear_round_sums();
    tick_m = 0; st_m = 0; sv_m = 0;
    stsq_m = 0; stv_m = 0; svsq_m = 0;
    min_m = 16'hFFFF; max_m = 0;
  endtask

  // Advance the predictor by one accepted code; queue a round result if it closes
  task automatic accumulate_sample(logic [15:0] v);
    logic [63:0] t64, v64, n64, p, q, mag, den, mean64, r64;
    w128_t a, b, d, quo;
    result_t res;
    logic neg;
    if (stopped_m) return;
    t64 = tick_m;
    v64 = v;
    st_m = st_m + 32'(t64);
    sv_m = sv_m + 32'(v64);
    stsq_m = stsq_m + 48'(t64 * t64);
    stv_m = stv_m + 48'(t64 * v64);
    svsq_m = svsq_m + 48'(v64 * v64);
    if (v < min_m) min_m = v;
    if (v > max_m) max_m = v;
    tick_m = tick_m + 16'd1;
    n64 = tick_m;
    if (tick_m < spr_m && tick_m != COUNT_MAX) return;

    mean64 = ({32'b0, sv_m} << 8) / n64;
    res.mean_q8 = mean64[23:0];
    mean64 = res.mean_q8;
    a = w128_t'(n64) * w128_t'(svsq_m);
    b = w128_t'(sv_m) * w128_t'(sv_m);
    if (a < b) res.std_q8 = 0;
    else begin
      d = (a - b) << 16;
      res.std_q8 = root_ratio_q8(d, n64 * n64);
    end

    res.slope_q16 = 0;
    a = w128_t'(n64) * w128_t'(stsq_m);
    b = w128_t'(st_m) * w128_t'(st_m);
    if (b < a) begin
      d = a - b;
      den = d[63:0];
      p = n64 * {16'b0, stv_m};
      q = {32'b0, st_m} * {32'b0, sv_m};
      neg = p < q;
      mag = neg ? q - p : p - q;
      quo = (w128_t'(mag) * w128_t'(SLOPE_SCALE)) / w128_t'(den);
      if (quo[127:64] != 0 || quo[63:0] > 64'h7FFFFFFFFFFF)
        mag = neg ? 64'h800000000000 : 64'h7FFFFFFFFFFF;
      else
        mag = quo[63:0];
      res.slope_q16 = neg ? 48'(64'd0 - mag) : mag[47:0];
    end

    rounds_m = rounds_m + 10'd1;
    som_m = som_m + 34'(mean64);
    soms_m = soms_m + 58'(mean64 * mean64);
    r64 = rounds_m;
    if (rounds_m == 0) begin
      res.zero_offset_q8 = 0;
      res.floor_noise_q8 = 0;
    end else begin
      res.zero_offset_q8 = 24'({30'b0, som_m} / r64);
      a = w128_t'(r64) * w128_t'(soms_m);
      b = w128_t'(som_m) * w128_t'(som_m);
      res.floor_noise_q8 = (a < b) ? 24'd0 : root_ratio_q8(a - b, r64 * r64);
    end
    res.min_code = min_m;
    res.max_code = max_m;
    res.railed = (max_m >= rail_hi_m) || (min_m <= rail_lo_m);
    res.round_index = rounds_m;
    res.all_done = (rounds_m >= rounds_total_m) || (rounds_m == ROUND_MAX);
    round_results_due.push_back(res);
    clear_round_sums();
    if (res.all_done) stopped_m = 1;
  endtask

  // Sender gap: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (fast_feed) return (r < 98) ? 0 : $urandom_range(1, 3);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 200);
  endfunction

  // Offer one code; hold push high until the block takes it
  task automatic send_sample(logic [15:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_sample <= v;
    do @(posedge clk); while (full);
    accumulate_sample(v);
    samples_sent++;
  endtask

  // Drop push, drain every pending result, then let the math engine settle
  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk);
    while (round_results_due.size() != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
  endtask

  // Two-phase register write; upper pwdata bits are junk the block must ignore
  task automatic write_reg(reg_idx_t idx, logic [15:0] value);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= 4'(idx) << 2;
    pwdata <= {16'($urandom_range(0, 65535)), 16'h0} | ((idx == REG_ROUNDS) ?
              {16'h0, 6'($urandom_range(0, 63)), value[9:0]} : {16'h0, value});
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_SPR:       spr_m = value;
      REG_ROUNDS:    rounds_total_m = value[9:0];
      REG_RAIL_HIGH: rail_hi_m = value;
      REG_RAIL_LOW:  rail_lo_m = value;
    endcase
    @(posedge clk);
  endtask

  task automatic report_mismatch(string field, logic [63:0] seen, logic [63:0] want);
    errors++;
    $display("round %0d: %s got %0h expected %0h", rounds_seen, field, seen, want);
  endtask

  // Receiver: random pop with occasional long holds
  int hold_cnt = 0;
  int pop_pct = 70;
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      pop <= 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) hold_cnt <= $urandom_range(30, 300);
      if ($urandom_range(0, 499) == 0) pop_pct <= $urandom_range(0, 3) * 33 + 1;
      pop <= ($urandom_range(0, 99) < pop_pct);
    end
  end

  // Checker: compare each popped item with the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (rst_n && pop && !empty) begin
      rounds_seen++;
      if (round_results_due.size() == 0) begin
        report_mismatch("unexpected item", 64'(got.round_index), 64'd0);
      end else begin
        want = round_results_due.pop_front();
        if (got.mean_q8 !== want.mean_q8) report_mismatch("mean", got.mean_q8, want.mean_q8);
        if (got.std_q8 !== want.std_q8) report_mismatch("std", got.std_q8, want.std_q8);
        if (got.slope_q16 !== want.slope_q16)
          report_mismatch("slope", got.slope_q16, want.slope_q16);
        if (got.min_code !== want.min_code) report_mismatch("min", got.min_code, want.min_code);
        if (got.max_code !== want.max_code) report_mismatch("max", got.max_code, want.max_code);
        if (got.railed !== want.railed) report_mismatch("railed", got.railed, want.railed);
        if (got.round_index !== want.round_index)
          report_mismatch("round_index", got.round_index, want.round_index);
        if (got.zero_offset_q8 !== want.zero_offset_q8)
          report_mismatch("zero_offset", got.zero_offset_q8, want.zero_offset_q8);
        if (got.floor_noise_q8 !== want.floor_noise_q8)
          report_mismatch("floor_noise", got.floor_noise_q8, want.floor_noise_q8);
        if (got.all_done !== want.all_done)
          report_mismatch("all_done", got.all_done, want.all_done);
      end
    end
  end

  // Extremes, equal codes and a full-swing pair in two-sample rounds
  task automatic test_directed_extremes();
    write_reg(REG_SPR, 16'd2);
    write_reg(REG_ROUNDS, 10'd1023);
    write_reg(REG_RAIL_HIGH, 16'hFF00);
    write_reg(REG_RAIL_LOW, 16'h00FF);
    send_sample(16'h0000); send_sample(16'hFFFF);
    send_sample(16'hFFFF); send_sample(16'h0000);
    send_sample(16'h8000); send_sample(16'h8000);
    send_sample(16'h00FF); send_sample(16'hFF00);
    send_sample(16'h0100); send_sample(16'hFEFF);
    send_sample(16'h5555); send_sample(16'hAAAA);
    wait_idle();
  endtask

  // Count of zero or one closes a round on every sample; slope is zero
  task automatic test_tiny_counts();
    write_reg(REG_SPR, 16'd0);
    send_sample(16'h1234); send_sample(16'hFFFF);
    wait_idle();
    write_reg(REG_SPR, 16'd1);
    send_sample(16'h0000); send_sample(16'h7FFF);
    wait_idle();
  endtask

  // Lower the count below the running tick; next sample closes the round
  task automatic test_count_lowered();
    write_reg(REG_SPR, 16'd10);
    repeat (5) send_sample(16'($urandom_range(0, 65535)));
    wait_idle();
    write_reg(REG_SPR, 16'd3);
    send_sample(16'hC000);
    wait_idle();
  endtask

  // Random phases: new settings, then rounds of ramps, flats and noise
  task automatic test_random_rounds(int target);
    int kind, len, base, step;
    while (samples_sent < target) begin
      write_reg(REG_SPR, ($urandom_range(0, 9) < 8) ? 16'($urandom_range(2, 12))
                                                     : 16'($urandom_range(13, 64)));
      case ($urandom_range(0, 3))
        0: begin write_reg(REG_RAIL_HIGH, 16'hFFFF); write_reg(REG_RAIL_LOW, 16'h0000); end
        1: begin write_reg(REG_RAIL_HIGH, 16'h0000); write_reg(REG_RAIL_LOW, 16'hFFFF); end
        default: begin
          write_reg(REG_RAIL_HIGH, 16'($urandom_range(0, 65535)));
          write_reg(REG_RAIL_LOW, 16'($urandom_range(0, 65535)));
        end
      endcase
      len = $urandom_range(40, 160);
      while (len > 0) begin
        kind = $urandom_range(0, 3);
        base = $urandom_range(0, 65535);
        step = $urandom_range(0, 1) ? $urandom_range(0, 2000) : -$urandom_range(0, 2000);
        repeat ($urandom_range(2, 16)) begin
          case (kind)
            0: send_sample(16'(base));
            1: begin send_sample(16'(base)); base = base + step; end
            2: send_sample(16'(base + $urandom_range(0, 64) - 32));
            default: send_sample(16'($urandom_range(0, 65535)));
          endcase
          len--;
        end
      end
      wait_idle();
    end
  endtask

  // One long back-to-back round with large time sums
  task automatic test_longest_round();
    fast_feed = 1;
    write_reg(REG_SPR, 16'd250);
    repeat (250) send_sample(16'($urandom_range(0, 65535)));
    fast_feed = 0;
    wait_idle();
  endtask

  // Round total at or below rounds done: next round is final, then drop items
  task automatic test_stop();
    write_reg(REG_SPR, 16'd3);
    write_reg(REG_ROUNDS, 10'd1);
    repeat (3) send_sample(16'($urandom_range(0, 65535)));
    repeat (20) send_sample(16'($urandom_range(0, 65535)));
    wait_idle();
    write_reg(REG_ROUNDS, 10'd0);
    repeat (10) send_sample(16'($urandom_range(0, 65535)));
    wait_idle();
  endtask

  initial begin
    rst_n = 1'b0;
    push = 1'b0; in_sample = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    spr_m = SPR_RESET; rounds_total_m = ROUNDS_RESET[9:0];
    rail_hi_m = RAIL_HIGH_RESET; rail_lo_m = RAIL_LOW_RESET;
    rounds_m = 0; som_m = 0; soms_m = 0; stopped_m = 0;
    clear_round_sums();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_extremes();
    test_tiny_counts();
    test_count_lowered();
    test_random_rounds(1400);
    test_longest_round();
    test_stop();

    $display("sent %0d samples, checked %0d round results", samples_sent, rounds_seen);
    $display("covered tiny, lowered, random and long counts, rails and stop");
    if (errors == 0 && round_results_due.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

### filelist.f
sv/zors_pkg.sv
sv/zors_front.sv
sv/zors_queue.sv
sv/zors_arith.sv
sv/zors_back.sv
sv/zero_offset_regression_stats.sv
sv/zors_checker.sv
tb/tb_zero_offset_regression_stats.sv
